@@ sv/cstp_pkg.sv @@
// Shared constants and types for the call stack exclusive time profiler.
`default_nettype none
package cstp_pkg;

  localparam int DEF_FUNC_COUNT  = 64;
  localparam int DEF_STACK_DEPTH = 64;

  localparam int ID_W    = 6;
  localparam int TS_W    = 32;
  localparam int TOTAL_W = 32;
  localparam int BND_W   = TS_W + 1;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  localparam logic EV_START = 1'b0;
  localparam logic EV_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage
`default_nettype wire

@@ sv/call_stack_exclusive_time_profiler_core.sv @@
// Top level of the call stack exclusive time profiler.
//
//  channel  | direction | tdata (low bit up)               | tuser (low bit up)
//  s_axis   | in        | func_id[5:0], timestamp[37:6]    | req_type[0]
//  m_axis   | out       | credited_id[5:0], total[37:6]    | credit_valid[0], status[2:1]
//
// An event passes through four steps: accept, call stack read, totals read and add, write-back.
// The two registered memory reads lie in series.
// After reset the totals memory is cleared, one entry a cycle, through all FUNC_COUNT entries;
// s_axis_tready stays low during the clear.
// A result waits in the output register; the next event is accepted meanwhile, and
// write-back holds while an earlier result has not been taken.
`default_nettype none
module call_stack_exclusive_time_profiler_core #(
  parameter int FUNC_COUNT  = cstp_pkg::DEF_FUNC_COUNT,
  parameter int STACK_DEPTH = cstp_pkg::DEF_STACK_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // func_id, timestamp, zero fill
  input  wire logic [cstp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type
  input  wire logic [cstp_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // credited_id, credited_total, zero fill
  output logic      [cstp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // credit_valid, event_status
  output logic      [cstp_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  localparam int FA_W = $clog2(FUNC_COUNT);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SC_W = $clog2(STACK_DEPTH + 1);
  localparam int ID_W = cstp_pkg::ID_W;
  localparam int TS_W = cstp_pkg::TS_W;
  localparam int TW   = cstp_pkg::TOTAL_W;
  localparam int BW   = cstp_pkg::BND_W;
  localparam int IDS  = 1 << ID_W;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_RD1  = 5'b00100,
    S_RD2  = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  state_t state;

  logic                 ev_end;
  logic [ID_W-1:0]      ev_fid;
  logic [TS_W-1:0]      ev_ts;
  logic [SC_W-1:0]      count;
  logic [BW-1:0]        boundary;
  logic [FA_W-1:0]      clr_idx;
  logic [ID_W-1:0]      top_id;
  logic [BW-1:0]        elapsed;
  logic [BW-1:0]        new_bnd;
  logic [TW-1:0]        total;
  logic                 credit;
  logic                 do_push;
  logic                 do_pop;
  cstp_pkg::status_t    status;

  logic [ID_W-1:0]      fid_mod [IDS];
  logic [SC_W-1:0]      cnt_m1;
  logic                 full;
  logic                 empty;
  logic [BW-1:0]        now_pt;
  logic [TW+1:0]        sum;
  logic                 fire;

  logic                 tot_we;
  logic [FA_W-1:0]      tot_waddr;
  logic [TW-1:0]        tot_wdata;
  logic [FA_W-1:0]      tot_raddr;
  logic [TW-1:0]        tot_rdata;
  logic [ID_W-1:0]      stk_rdata;

  always_comb begin
    for (int i = 0; i < IDS; i++) begin
      fid_mod[i] = ID_W'(i % FUNC_COUNT);
    end
  end

  assign cnt_m1 = count - SC_W'(1);
  assign full   = (count == SC_W'(STACK_DEPTH));
  assign empty  = (count == '0);
  assign now_pt = ev_end ? ({1'b0, ev_ts} + BW'(1)) : {1'b0, ev_ts};
  assign sum    = {2'b00, tot_rdata} + {1'b0, elapsed};
  assign fire   = (state == S_RES) && (!m_axis_tvalid || m_axis_tready);

  assign s_axis_tready = (state == S_IDLE);

  assign tot_we    = (state == S_CLR) || (fire && credit);
  assign tot_waddr = (state == S_CLR) ? clr_idx : FA_W'(top_id);
  assign tot_wdata = (state == S_CLR) ? '0 : total;
  assign tot_raddr = FA_W'(stk_rdata);

  cstp_ram #(.WIDTH(TW), .DEPTH(FUNC_COUNT)) u_totals (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (tot_raddr),
    .rdata (tot_rdata)
  );

  cstp_ram #(.WIDTH(ID_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (fire && do_push),
    .waddr (count[SA_W-1:0]),
    .wdata (fid_mod[ev_fid]),
    .raddr (cnt_m1[SA_W-1:0]),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_idx       <= '0;
      count         <= '0;
      boundary      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + FA_W'(1);
          if (clr_idx == FA_W'(FUNC_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_RD1;
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_RES;
        end
        S_RES: begin
          if (fire) begin
            if (do_push) begin
              count    <= count + SC_W'(1);
              boundary <= new_bnd;
            end
            if (do_pop) begin
              count    <= cnt_m1;
              boundary <= new_bnd;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ev_end <= s_axis_tuser[0];
      ev_fid <= s_axis_tdata[ID_W-1:0];
      ev_ts  <= s_axis_tdata[ID_W+TS_W-1:ID_W];
    end
    if (state == S_RD1) begin
      top_id  <= stk_rdata;
      new_bnd <= now_pt;
      elapsed <= (now_pt >= boundary) ? (now_pt - boundary) : '0;
      do_push <= (ev_end == cstp_pkg::EV_START) && !full;
      do_pop  <= (ev_end == cstp_pkg::EV_END) && !empty;
      credit  <= !empty && ((ev_end == cstp_pkg::EV_END) || !full);
      if ((ev_end == cstp_pkg::EV_START) && full) begin
        status <= cstp_pkg::ST_FULL;
      end else if ((ev_end == cstp_pkg::EV_END) && empty) begin
        status <= cstp_pkg::ST_EMPTY;
      end else begin
        status <= cstp_pkg::ST_OK;
      end
    end
    if (state == S_RD2) begin
      total <= (sum[TW+1:TW] != 2'b00) ? {TW{1'b1}} : sum[TW-1:0];
    end
    if (fire) begin
      m_axis_tdata <= credit ? {2'b00, total, top_id} : '0;
      m_axis_tuser <= {status, credit};
    end
  end

endmodule
`default_nettype wire

@@ sv/cstp_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module cstp_ram #(
  parameter int WIDTH = cstp_pkg::TOTAL_W,
  parameter int DEPTH = cstp_pkg::DEF_FUNC_COUNT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/cstp_checker.sv @@
// Port-level checker for the call stack exclusive time profiler, bound to the top level.
`default_nettype none
module cstp_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [cstp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input wire logic [cstp_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [cstp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic [cstp_pkg::OUT_USER_W-1:0]   m_axis_tuser
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Time is credited only on events that completed normally.
  a_credit_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tuser[2:1] == cstp_pkg::ST_OK)
    else $error("credit reported with a failure status");

  // Without credit the id and total read as zero.
  a_no_credit_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("payload not zero on a beat without credit");

  // The status code is always one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tuser[2:1] == cstp_pkg::ST_OK) ||
      (m_axis_tuser[2:1] == cstp_pkg::ST_FULL) ||
      (m_axis_tuser[2:1] == cstp_pkg::ST_EMPTY))
    else $error("undefined status code");

  // One event is in process at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("event accepted while another was in process");

endmodule

bind call_stack_exclusive_time_profiler_core cstp_checker u_cstp_checker (.*);
`default_nettype wire
